// ----- sv/skrf_pkg.sv -----
`default_nettype none
package skrf_pkg;

    localparam int FRACTION_BITS = 16;

    // Register reset values, Q16.16 with FRACTION_BITS fraction bits
    localparam logic [31:0] INIT_VAR_RESET = 32'(64'd10 << FRACTION_BITS);
    localparam logic [31:0] MEAS_VAR_RESET = 32'(64'd1 << (FRACTION_BITS - 1));
    localparam logic [31:0] PROC_VAR_RESET = 32'(64'd4 << FRACTION_BITS);

    // Register indexes, paddr[3:2]
    localparam logic [1:0] REG_INIT_VAR = 2'd0;
    localparam logic [1:0] REG_MEAS_VAR = 2'd1;
    localparam logic [1:0] REG_PROC_VAR = 2'd2;

    typedef logic [4:0] t_upc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_GYRO,
        OP_SEED,
        OP_PREDICT,
        OP_SUM,
        OP_SCALE,
        OP_MUL_RE,
        OP_MUL_PG,
        OP_ADD_NUM,
        OP_ABS,
        OP_DIV,
        OP_RATE,
        OP_MUL_PR,
        OP_VAR,
        OP_ZVAR,
        OP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ITEM,
        C_INVALID,
        C_ODO,
        C_SEEDED,
        C_SZERO,
        C_DIV_BUSY,
        C_OUT_BLOCKED
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    typedef struct packed {
        logic no_item;
        logic invalid;
        logic odo;
        logic seeded;
        logic s_zero;
        logic div_busy;
        logic out_blocked;
    } t_flags;

    // Program entry points and jump targets
    localparam t_upc STEP_IDLE      = 5'd0;
    localparam t_upc STEP_ODO       = 5'd4;
    localparam t_upc STEP_PREDICT   = 5'd6;
    localparam t_upc STEP_DIV1_WAIT = 5'd15;
    localparam t_upc STEP_DIV2_WAIT = 5'd19;
    localparam t_upc STEP_OUT_WAIT  = 5'd21;
    localparam t_upc STEP_ZERO      = 5'd23;

    function automatic t_uword mk(input t_uop op, input t_ucond cond, input t_upc target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            5'd0:    w = mk(OP_NOP,     C_NO_ITEM,     STEP_IDLE);
            5'd1:    w = mk(OP_NOP,     C_INVALID,     STEP_IDLE);
            5'd2:    w = mk(OP_NOP,     C_ODO,         STEP_ODO);
            5'd3:    w = mk(OP_GYRO,    C_ALWAYS,      STEP_IDLE);
            5'd4:    w = mk(OP_NOP,     C_SEEDED,      STEP_PREDICT);
            5'd5:    w = mk(OP_SEED,    C_ALWAYS,      STEP_IDLE);
            5'd6:    w = mk(OP_PREDICT, C_NEXT,        STEP_IDLE);
            5'd7:    w = mk(OP_SUM,     C_NEXT,        STEP_IDLE);
            5'd8:    w = mk(OP_NOP,     C_SZERO,       STEP_ZERO);
            5'd9:    w = mk(OP_SCALE,   C_NEXT,        STEP_IDLE);
            5'd10:   w = mk(OP_MUL_RE,  C_NEXT,        STEP_IDLE);
            5'd11:   w = mk(OP_MUL_PG,  C_NEXT,        STEP_IDLE);
            5'd12:   w = mk(OP_ADD_NUM, C_NEXT,        STEP_IDLE);
            5'd13:   w = mk(OP_ABS,     C_NEXT,        STEP_IDLE);
            5'd14:   w = mk(OP_DIV,     C_NEXT,        STEP_IDLE);
            5'd15:   w = mk(OP_NOP,     C_DIV_BUSY,    STEP_DIV1_WAIT);
            5'd16:   w = mk(OP_RATE,    C_NEXT,        STEP_IDLE);
            5'd17:   w = mk(OP_MUL_PR,  C_NEXT,        STEP_IDLE);
            5'd18:   w = mk(OP_DIV,     C_NEXT,        STEP_IDLE);
            5'd19:   w = mk(OP_NOP,     C_DIV_BUSY,    STEP_DIV2_WAIT);
            5'd20:   w = mk(OP_VAR,     C_NEXT,        STEP_IDLE);
            5'd21:   w = mk(OP_NOP,     C_OUT_BLOCKED, STEP_OUT_WAIT);
            5'd22:   w = mk(OP_EMIT,    C_ALWAYS,      STEP_IDLE);
            5'd23:   w = mk(OP_ZVAR,    C_ALWAYS,      STEP_OUT_WAIT);
            default: w = mk(OP_NOP,     C_ALWAYS,      STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/skrf_div.sv -----
`default_nettype none
// Unsigned 64 / 32 restoring divider, two quotient bits per cycle.
// Needs dividend[63:32] < divisor so the quotient fits in 32 bits.
module skrf_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_dividend,
    input  wire  [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);

    localparam logic [4:0] DIV_STEPS = 5'd16;

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dsr;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [32:0] s1, s2;

    // {quotient bit, new remainder}
    function automatic logic [32:0] div_bit(input logic [31:0] rem, input logic bin,
                                            input logic [31:0] dsr);
        logic [32:0] t;
        logic [32:0] d;
        t = {rem, bin};
        d = t - {1'b0, dsr};
        if (t >= {1'b0, dsr}) begin
            return {1'b1, d[31:0]};
        end
        return {1'b0, t[31:0]};
    endfunction

    always_comb begin
        s1    = div_bit(r_rem, r_quo[31], r_dsr);
        s2    = div_bit(s1[31:0], r_quo[30], r_dsr);
        n_rem = s2[31:0];
        n_quo = {r_quo[29:0], s1[32], s2[32]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_quo <= i_dividend[31:0];
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_dividend[63:32] < i_divisor))
        else $error("divider quotient would overflow");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 5'd0))
        else $error("divider busy with no steps left");

endmodule
`default_nettype wire

// ----- sv/skrf_seq.sv -----
`default_nettype none
// Microcode sequencer: step counter, control ROM, conditional jumps.
module skrf_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire skrf_pkg::t_flags i_flags,
    output skrf_pkg::t_uword      o_uword,
    output logic                  o_idle
);

    skrf_pkg::t_upc r_pc, n_pc;
    logic           take;

    always_comb begin
        o_uword = skrf_pkg::ucode(r_pc);
        case (o_uword.cond)
            skrf_pkg::C_NEXT:        take = 1'b0;
            skrf_pkg::C_ALWAYS:      take = 1'b1;
            skrf_pkg::C_NO_ITEM:     take = i_flags.no_item;
            skrf_pkg::C_INVALID:     take = i_flags.invalid;
            skrf_pkg::C_ODO:         take = i_flags.odo;
            skrf_pkg::C_SEEDED:      take = i_flags.seeded;
            skrf_pkg::C_SZERO:       take = i_flags.s_zero;
            skrf_pkg::C_DIV_BUSY:    take = i_flags.div_busy;
            skrf_pkg::C_OUT_BLOCKED: take = i_flags.out_blocked;
            default:                 take = 1'b0;
        endcase
        n_pc = take ? o_uword.target : r_pc + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= skrf_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_idle = (r_pc == skrf_pkg::STEP_IDLE);

endmodule
`default_nettype wire

// ----- sv/skrf_dp.sv -----
`default_nettype none
// Filter datapath: state registers, shared multiplier, divider, output register.
module skrf_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire                   i_cmd,
    input  wire signed [31:0]     i_rate_sample,
    input  wire                   i_sample_valid,
    input  wire        [31:0]     i_init_var,
    input  wire        [31:0]     i_meas_var,
    input  wire        [31:0]     i_proc_var,
    input  wire                   i_out_stall,
    input  wire skrf_pkg::t_uword i_uword,
    output skrf_pkg::t_flags      o_flags,
    output logic                  o_out_valid,
    output logic signed [31:0]    o_fused_rate,
    output logic        [31:0]    o_fused_variance
);

    skrf_pkg::t_uop op;

    // latched item
    logic        r_cmd;
    logic        r_valid;
    logic [31:0] r_sample;

    // filter state
    logic [31:0] r_est;
    logic [31:0] r_var;
    logic [31:0] r_gyro;
    logic [31:0] r_prev;
    logic        r_awaiting;

    // fusion scratch
    logic [32:0] r_s;
    logic [31:0] r_p;
    logic [31:0] r_r;
    logic        r_k;
    logic [63:0] r_m1;
    logic [63:0] r_m2;
    logic [64:0] r_num;
    logic        r_neg;
    logic [63:0] r_dvd;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_rate;
    logic [31:0] r_out_var;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    logic [33:0] pred_sum;
    logic [31:0] pred_est;
    logic [32:0] var_sum;
    logic [32:0] pr_sum;
    logic [32:0] half_sum;
    logic [64:0] num_sum;
    logic [64:0] num_neg;
    logic        div_busy;
    logic [31:0] div_quo;
    logic        div_start;

    assign op = i_uword.op;

    always_comb begin
        case (op)
            skrf_pkg::OP_MUL_RE: begin
                mul_a = $signed({1'b0, r_r});
                mul_b = $signed({r_est[31], r_est});
            end
            skrf_pkg::OP_MUL_PG: begin
                mul_a = $signed({1'b0, r_p});
                mul_b = $signed({r_gyro[31], r_gyro});
            end
            default: begin
                mul_a = $signed({1'b0, r_p});
                mul_b = $signed({1'b0, r_r});
            end
        endcase
        mul_prod = mul_a * mul_b;
    end

    always_comb begin
        pred_sum = {{2{r_est[31]}}, r_est} + {{2{r_sample[31]}}, r_sample}
                 - {{2{r_prev[31]}}, r_prev};
        // saturate when the top three bits disagree
        if (pred_sum[33:31] == 3'b000 || pred_sum[33:31] == 3'b111) begin
            pred_est = pred_sum[31:0];
        end else if (pred_sum[33]) begin
            pred_est = 32'h8000_0000;
        end else begin
            pred_est = 32'h7FFF_FFFF;
        end
        var_sum  = {1'b0, r_var} + {1'b0, i_proc_var};
        pr_sum   = {1'b0, r_var} + {1'b0, i_meas_var};
        half_sum = {2'b00, r_var[31:1]} + {2'b00, i_meas_var[31:1]};
        num_sum  = {r_m1[63], r_m1} + {r_m2[63], r_m2};
        num_neg  = 65'd0 - r_num;
    end

    assign div_start = (op == skrf_pkg::OP_DIV);

    skrf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_s[31:0]),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= '0;
            r_var       <= skrf_pkg::INIT_VAR_RESET;
            r_gyro      <= '0;
            r_prev      <= '0;
            r_awaiting  <= 1'b1;
            r_valid     <= 1'b0;
            r_cmd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_cmd   <= i_cmd;
                r_valid <= i_sample_valid;
            end
            case (op)
                skrf_pkg::OP_GYRO: r_gyro <= r_sample;
                skrf_pkg::OP_SEED: begin
                    r_est      <= r_sample;
                    r_prev     <= r_sample;
                    r_var      <= i_init_var;
                    r_awaiting <= 1'b0;
                end
                skrf_pkg::OP_PREDICT: begin
                    r_est  <= pred_est;
                    r_prev <= r_sample;
                    r_var  <= var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
                end
                skrf_pkg::OP_RATE: r_est <= r_neg ? 32'd0 - div_quo : div_quo;
                skrf_pkg::OP_VAR: begin
                    if (!r_k) begin
                        r_var <= div_quo;
                    end else if (div_quo[31]) begin
                        r_var <= 32'hFFFF_FFFF;
                    end else begin
                        r_var <= {div_quo[30:0], 1'b0};
                    end
                end
                skrf_pkg::OP_ZVAR: r_var <= '0;
                default: ;
            endcase
            if (op == skrf_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample <= i_rate_sample;
        end
        case (op)
            skrf_pkg::OP_SUM: r_s <= pr_sum;
            skrf_pkg::OP_SCALE: begin
                // P + R above 32 bits: halve both
                if (r_s[32]) begin
                    r_p <= {1'b0, r_var[31:1]};
                    r_r <= {1'b0, i_meas_var[31:1]};
                    r_k <= 1'b1;
                    r_s <= half_sum;
                end else begin
                    r_p <= r_var;
                    r_r <= i_meas_var;
                    r_k <= 1'b0;
                end
            end
            skrf_pkg::OP_MUL_RE: r_m1  <= mul_prod[63:0];
            skrf_pkg::OP_MUL_PG: r_m2  <= mul_prod[63:0];
            skrf_pkg::OP_ADD_NUM: r_num <= num_sum;
            skrf_pkg::OP_ABS: begin
                r_neg <= r_num[64];
                r_dvd <= r_num[64] ? num_neg[63:0] : r_num[63:0];
            end
            skrf_pkg::OP_MUL_PR: r_dvd <= mul_prod[63:0];
            skrf_pkg::OP_EMIT: begin
                r_out_rate <= r_est;
                r_out_var  <= r_var;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_flags.no_item     = !i_accept;
        o_flags.invalid     = !r_valid;
        o_flags.odo         = r_cmd;
        o_flags.seeded      = !r_awaiting;
        o_flags.s_zero      = (r_s == 33'd0);
        o_flags.div_busy    = div_busy;
        o_flags.out_blocked = r_out_valid && i_out_stall;
    end

    assign o_out_valid      = r_out_valid;
    assign o_fused_rate     = $signed(r_out_rate);
    assign o_fused_variance = r_out_var;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == skrf_pkg::OP_EMIT) |-> !r_out_valid)
        else $error("result written over an untaken beat");

    a_divisor_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == skrf_pkg::OP_DIV) |-> (!r_s[32] && r_s != 33'd0))
        else $error("divisor out of range");

    a_rate_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == skrf_pkg::OP_RATE) |->
            (!div_quo[31] || (r_neg && div_quo[30:0] == 31'd0)))
        else $error("fused rate quotient out of range");

endmodule
`default_nettype wire

// ----- sv/scalar_kalman_rate_filter_core.sv -----
// Gyro, invalid and first-odometry items produce no result.
// Fused odometry item: one result beat, after two full passes of the 2-bit
// divider; the next item is taken only once the sequencer is back at idle.
// Zero P + R skips the divides and clears the variance.
// Synchronous active-low reset: sequencer idle, registers at defaults,
// estimate and gyro cleared, waiting for the first odometry sample.
`default_nettype none
module scalar_kalman_rate_filter_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // item channel
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_cmd,
    input  wire signed [31:0]  i_rate_sample,
    input  wire                i_sample_valid,
    // result channel
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_fused_rate,
    output logic        [31:0] o_fused_variance,
    // register port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire         [3:0]  paddr,
    input  wire         [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    logic [31:0] r_init_var;
    logic [31:0] r_meas_var;
    logic [31:0] r_proc_var;
    logic        cfg_wr;
    logic        idle;
    logic        accept;

    skrf_pkg::t_flags flags;
    skrf_pkg::t_uword uword;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_var <= skrf_pkg::INIT_VAR_RESET;
            r_meas_var <= skrf_pkg::MEAS_VAR_RESET;
            r_proc_var <= skrf_pkg::PROC_VAR_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                skrf_pkg::REG_INIT_VAR: r_init_var <= pwdata;
                skrf_pkg::REG_MEAS_VAR: r_meas_var <= pwdata;
                skrf_pkg::REG_PROC_VAR: r_proc_var <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            skrf_pkg::REG_INIT_VAR: prdata = r_init_var;
            skrf_pkg::REG_MEAS_VAR: prdata = r_meas_var;
            skrf_pkg::REG_PROC_VAR: prdata = r_proc_var;
            default:                prdata = '0;
        endcase
    end

    assign o_in_stall = !idle;
    assign accept     = i_in_valid && idle;

    skrf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword),
        .o_idle  (idle)
    );

    skrf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_cmd            (i_cmd),
        .i_rate_sample    (i_rate_sample),
        .i_sample_valid   (i_sample_valid),
        .i_init_var       (r_init_var),
        .i_meas_var       (r_meas_var),
        .i_proc_var       (r_proc_var),
        .i_out_stall      (i_out_stall),
        .i_uword          (uword),
        .o_flags          (flags),
        .o_out_valid      (o_out_valid),
        .o_fused_rate     (o_fused_rate),
        .o_fused_variance (o_fused_variance)
    );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

    typedef enum bit {CMD_GYRO = 1'b0, CMD_ODO = 1'b1} t_cmd;

    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] rate;
        bit                 ok;
    } t_sample;

    typedef struct {
        logic signed [31:0] rate;
        logic        [31:0] variance;
    } t_fused;

    localparam logic signed [31:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RATE_MIN = 32'sh8000_0000;
    localparam logic        [31:0] VAR_MAX  = 32'hFFFF_FFFF;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 265;
    localparam int NUM_PHASES   = 6;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               i_cmd          = 1'b0;
    logic signed [31:0] i_rate_sample  = '0;
    logic               i_sample_valid = 1'b0;
    logic               i_out_stall    = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic        [3:0]  paddr          = '0;
    logic        [31:0] pwdata         = '0;
    wire                o_in_stall;
    wire                o_out_valid;
    wire signed  [31:0] o_fused_rate;
    wire         [31:0] o_fused_variance;
    wire         [31:0] prdata;
    wire                pready;

    scalar_kalman_rate_filter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_rate_sample    (i_rate_sample),
        .i_sample_valid   (i_sample_valid),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_fused_rate     (o_fused_rate),
        .o_fused_variance (o_fused_variance),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter registers and state as the block should hold them
    logic        [31:0] cfg_init_var = skrf_pkg::INIT_VAR_RESET;
    logic        [31:0] cfg_meas_var = skrf_pkg::MEAS_VAR_RESET;
    logic        [31:0] cfg_proc_var = skrf_pkg::PROC_VAR_RESET;
    logic signed [31:0] est_rate     = '0;
    logic        [31:0] est_var      = skrf_pkg::INIT_VAR_RESET;
    logic signed [31:0] gyro_rate    = '0;
    logic signed [31:0] prev_odo     = '0;
    bit                 seeded       = 1'b0;

    t_sample sample_q[$];
    t_fused  fused_expect[$];
    int      samples_queued = 0;
    int      samples_taken  = 0;
    int      results_seen   = 0;
    int      mismatches     = 0;
    int      in_gap = 0, in_calm = 0, out_hold = 0, out_calm = 0;
    t_sample cur;

    function automatic logic signed [31:0] sat_rate(longint v);
        if (v > longint'(RATE_MAX)) return RATE_MAX;
        if (v < longint'(RATE_MIN)) return RATE_MIN;
        return 32'(v);
    endfunction

    function automatic logic [31:0] sat_var(logic [64:0] v);
        return (v > 65'(VAR_MAX)) ? VAR_MAX : v[31:0];
    endfunction

    // Advance the filter by one accepted sample, queue the fused result if any.
    task automatic track_sample(t_sample s);
        logic [63:0] p, r, sum, quo;
        longint      num;
        bit          halved;
        t_fused      res;
        if (!s.ok) return;
        if (s.cmd == CMD_GYRO) begin
            gyro_rate = s.rate;
            return;
        end
        if (!seeded) begin
            est_rate = s.rate;
            prev_odo = s.rate;
            est_var  = cfg_init_var;
            seeded   = 1'b1;
            return;
        end
        est_rate = sat_rate(longint'(est_rate) + longint'(s.rate) - longint'(prev_odo));
        prev_odo = s.rate;
        est_var  = sat_var(65'(est_var) + 65'(cfg_proc_var));
        p   = 64'(est_var);
        r   = 64'(cfg_meas_var);
        sum = p + r;
        if (sum == 0) begin
            est_var = '0;
        end else begin
            // keep P + R within 32 bits; variance is scaled back afterwards
            halved = (sum > 64'(VAR_MAX));
            if (halved) begin
                p   = p >> 1;
                r   = r >> 1;
                sum = p + r;
            end
            num      = $signed(r) * longint'(est_rate) + $signed(p) * longint'(gyro_rate);
            est_rate = sat_rate(num / $signed(sum));
            quo      = (p * r) / sum;
            est_var  = sat_var(halved ? {quo, 1'b0} : {1'b0, quo});
        end
        res.rate     = est_rate;
        res.variance = est_var;
        fused_expect.push_back(res);
    endtask

    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                track_sample(cur);
                samples_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    cur = sample_q.pop_front();
                    i_cmd          <= cur.cmd;
                    i_rate_sample  <= cur.rate;
                    i_sample_valid <= cur.ok;
                    i_in_valid     <= 1'b1;
                    in_gap = draw_wait(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor; stall is drawn per beat and burned while a beat is waiting
    always @(posedge i_clk) begin
        t_fused want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (fused_expect.size() == 0) begin
                    note_mismatch($sformatf("beat with nothing expected: rate %h var %h",
                                            o_fused_rate, o_fused_variance));
                end else begin
                    want = fused_expect.pop_front();
                    if (o_fused_rate !== want.rate)
                        note_mismatch($sformatf("beat %0d fused_rate exp %h got %h",
                                                results_seen, want.rate, o_fused_rate));
                    if (o_fused_variance !== want.variance)
                        note_mismatch($sformatf("beat %0d fused_variance exp %h got %h",
                                                results_seen, want.variance,
                                                o_fused_variance));
                end
                out_hold = draw_wait(out_calm);
            end else if (o_out_valid && out_hold > 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    task automatic push_sample(t_cmd cmd, logic signed [31:0] rate, bit ok);
        t_sample s;
        s.cmd  = cmd;
        s.rate = rate;
        s.ok   = ok;
        sample_q.push_back(s);
        samples_queued++;
    endtask

    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(0, 15))
            13:      return RATE_MAX;
            14:      return RATE_MIN;
            15:      return RATE_MAX - 32'($urandom_range(0, 255));
            9, 10, 11, 12: return $urandom;
            // mostly realistic rates within +/-8 rad/s
            default: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
        endcase
    endfunction

    task automatic queue_random(int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 7) begin
                push_sample(CMD_GYRO, rand_rate(), 1'b1);
                push_sample(CMD_ODO, rand_rate(), 1'b1);
                n += 2;
            end else begin
                push_sample(t_cmd'($urandom_range(0, 1)), rand_rate(),
                            $urandom_range(0, 3) != 0);
                n++;
            end
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            skrf_pkg::REG_INIT_VAR: cfg_init_var = val;
            skrf_pkg::REG_MEAS_VAR: cfg_meas_var = val;
            skrf_pkg::REG_PROC_VAR: cfg_proc_var = val;
            default: ;
        endcase
    endtask

    // wait for every sample to be taken and every result to be checked
    task automatic settle();
        while (samples_taken != samples_queued || fused_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] iv, mv, pv;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(skrf_pkg::REG_INIT_VAR, 32'h0003_0000);
        // invalid first odometry must not seed
        push_sample(CMD_ODO,  32'sh0001_2345, 1'b0);
        push_sample(CMD_GYRO, RATE_MIN,       1'b0);
        push_sample(CMD_GYRO, RATE_MAX,       1'b1);
        push_sample(CMD_ODO,  32'sh0001_0000, 1'b1);
        push_sample(CMD_ODO,  32'sh0002_0000, 1'b1);
        push_sample(CMD_GYRO, RATE_MIN,       1'b1);
        push_sample(CMD_ODO,  RATE_MAX,       1'b1);
        push_sample(CMD_ODO,  RATE_MIN,       1'b1);
        push_sample(CMD_ODO,  RATE_MAX,       1'b0);
        push_sample(CMD_GYRO, 32'sh0,         1'b1);
        push_sample(CMD_ODO,  -32'sd1,        1'b1);
        push_sample(CMD_ODO,  32'sh0,         1'b1);
        push_sample(CMD_GYRO, 32'sh0001_8000, 1'b1);
        push_sample(CMD_ODO,  RATE_MAX,       1'b1);
        push_sample(CMD_ODO,  RATE_MAX,       1'b1);
        push_sample(CMD_GYRO, RATE_MAX,       1'b1);
        push_sample(CMD_ODO,  RATE_MIN,       1'b1);
        push_sample(CMD_ODO,  RATE_MIN,       1'b1);
        push_sample(CMD_GYRO, RATE_MIN,       1'b0);
        push_sample(CMD_ODO,  32'sh5555_5555, 1'b1);
        push_sample(CMD_ODO,  32'shAAAA_AAAA, 1'b1);
        settle();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph)
                1: begin iv = '0;       mv = 32'd1;     pv = '0;      end
                2: begin iv = VAR_MAX;  mv = VAR_MAX;   pv = VAR_MAX; end
                3: begin
                    iv = $urandom;
                    mv = $urandom_range(32'h0004_0000, 1);
                    pv = $urandom_range(32'h0004_0000, 0);
                end
                4: begin iv = $urandom; mv = 32'h8000_0000; pv = 32'h4000_0000; end
                5: begin
                    iv = $urandom;
                    mv = $urandom_range(VAR_MAX, 1);
                    pv = $urandom;
                end
                default: begin
                    iv = skrf_pkg::INIT_VAR_RESET;
                    mv = skrf_pkg::MEAS_VAR_RESET;
                    pv = skrf_pkg::PROC_VAR_RESET;
                end
            endcase
            reg_write(skrf_pkg::REG_INIT_VAR, iv);
            reg_write(skrf_pkg::REG_MEAS_VAR, mv);
            reg_write(skrf_pkg::REG_PROC_VAR, pv);
            queue_random(PHASE_ITEMS);
            settle();
        end

        $display("Ran %0d samples through %0d register settings, checked %0d fused results",
                 samples_taken, NUM_PHASES + 1, results_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d of %0d samples taken, %0d results outstanding",
                 samples_taken, samples_queued, fused_expect.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
